// ----- rtl/core/ewsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ewsf_pkg;

  localparam int CNT_W     = 16;            // encoder count
  localparam int WEIGHT_W  = 16;            // Q0.16 weights and scale
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 34;            // four 16x16 products
  localparam int FILT_W    = ACC_W - FRAC_W;
  localparam int SPD_SHIFT = 8;
  localparam int SPD_W     = 26;
  localparam int PROD_W    = FILT_W + WEIGHT_W + 1;
  localparam int MAX_TAPS  = 4;

  localparam int REG_COUNT = 5;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP_ZERO    = 3'd0,
    REG_TAP_ONE     = 3'd1,
    REG_TAP_TWO     = 3'd2,
    REG_TAP_THREE   = 3'd3,
    REG_SPEED_SCALE = 3'd4
  } reg_idx_e;

  localparam logic [WEIGHT_W-1:0] TAP_RESET   = 16'd16384;  // 0.25
  localparam logic [WEIGHT_W-1:0] SCALE_RESET = 16'd47512;  // pi * 4.8 / 20.8

  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;

  typedef struct packed {
    logic signed [CNT_W-1:0] left;
    logic signed [CNT_W-1:0] right;
  } hist_t;

  // partial sum travelling down the tap chain
  typedef struct packed {
    logic                    valid;
    logic                    is_right;
    logic signed [ACC_W-1:0] psum;
  } tok_t;

  typedef struct packed {
    logic                     valid;
    logic                     is_right;
    logic signed [FILT_W-1:0] filt;
    logic signed [SPD_W-1:0]  speed;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ewsf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ewsf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ewsf_pkg::CNT_W-1:0]     left_count;
  logic signed [ewsf_pkg::CNT_W-1:0]     right_count;

  modport source (output valid, left_count, right_count, input ready);
  modport sink   (input valid, left_count, right_count, output ready);
endinterface

interface ewsf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ewsf_pkg::FILT_W-1:0]    left_filtered;
  logic signed [ewsf_pkg::FILT_W-1:0]    right_filtered;
  logic signed [ewsf_pkg::SPD_W-1:0]     left_speed;
  logic signed [ewsf_pkg::SPD_W-1:0]     right_speed;

  modport source (output valid, left_filtered, right_filtered, left_speed, right_speed,
                  input ready);
  modport sink   (input valid, left_filtered, right_filtered, left_speed, right_speed,
                  output ready);
endinterface

interface ewsf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ewsf_pkg::REG_IDX_W-1:0]        index;
  logic [ewsf_pkg::WEIGHT_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ewsf_tap_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ewsf_tap_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            shift_i,
  input  ewsf_pkg::hist_t                 hist_i,
  output ewsf_pkg::hist_t                 hist_o,
  input  logic [ewsf_pkg::WEIGHT_W-1:0]   weight_i,
  input  ewsf_pkg::tok_t                  tok_i,
  output ewsf_pkg::tok_t                  tok_o
);

  ewsf_pkg::hist_t hist_q;
  logic            valid_q;
  logic            is_right_q;
  logic signed [ewsf_pkg::ACC_W-1:0] psum_q;

  logic signed [ewsf_pkg::CNT_W-1:0]            sample;
  logic signed [ewsf_pkg::CNT_W+ewsf_pkg::WEIGHT_W:0] prod;

  assign sample = tok_i.is_right ? hist_q.right : hist_q.left;
  assign prod   = sample * $signed({1'b0, weight_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      valid_q    <= 1'b0;
      is_right_q <= 1'b0;
    end else begin
      if (shift_i) begin
        hist_q <= hist_i;
      end
      valid_q    <= tok_i.valid;
      is_right_q <= tok_i.is_right;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      psum_q <= tok_i.psum + ewsf_pkg::ACC_W'(prod);
    end
  end

  assign hist_o = hist_q;
  assign tok_o  = '{valid: valid_q, is_right: is_right_q, psum: psum_q};

endmodule

`default_nettype wire

// ----- rtl/core/ewsf_speed_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ewsf_speed_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ewsf_pkg::tok_t                  tok_i,
  input  logic [ewsf_pkg::WEIGHT_W-1:0]   scale_i,
  output ewsf_pkg::res_t                  res_o
);

  localparam int ACC_W  = ewsf_pkg::ACC_W;
  localparam int FRAC_W = ewsf_pkg::FRAC_W;

  logic                                 a_valid_q, a_right_q;
  logic signed [ewsf_pkg::FILT_W-1:0]   a_filt_q;
  logic                                 b_valid_q, b_right_q;
  logic signed [ewsf_pkg::FILT_W-1:0]   b_filt_q;
  logic signed [ewsf_pkg::SPD_W-1:0]    b_speed_q;

  logic signed [ACC_W-1:0]              biased;
  logic signed [ewsf_pkg::PROD_W-1:0]   prod;

  // adding 2^16-1 to a negative sum makes the arithmetic shift round toward zero
  assign biased = tok_i.psum + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{tok_i.psum[ACC_W-1]}}});
  assign prod   = a_filt_q * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_right_q <= 1'b0;
      b_valid_q <= 1'b0;
      b_right_q <= 1'b0;
    end else begin
      a_valid_q <= tok_i.valid;
      a_right_q <= tok_i.is_right;
      b_valid_q <= a_valid_q;
      b_right_q <= a_right_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      a_filt_q <= biased[ACC_W-1:FRAC_W];
    end
    if (a_valid_q) begin
      b_filt_q  <= a_filt_q;
      // floor shift by 8
      b_speed_q <= prod[ewsf_pkg::SPD_W+ewsf_pkg::SPD_SHIFT-1:ewsf_pkg::SPD_SHIFT];
    end
  end

  assign res_o = '{valid: b_valid_q, is_right: b_right_q, filt: b_filt_q, speed: b_speed_q};

endmodule

`default_nettype wire

// ----- rtl/core/encoder_weighted_speed_filter_unit.sv -----
// The accepted input beat is held in the count histories while its left and right partial
// sums walk the tap-cell chain, the two-stage truncate and speed-multiply unit, then the
// result and output registers. A new input beat is taken only once the previous result
// has been loaded into the output registers, so a stalled output also holds the input.
// Reset clears both count histories and loads the weights with 0.25 and the
// speed scale with 47512.
`timescale 1ns / 1ps
`default_nettype none

module encoder_weighted_speed_filter_unit #(
  parameter int WINDOW_TAPS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ewsf_in_if.sink           in_i,
  ewsf_out_if.source        out_o,
  ewsf_cfg_if.sink          cfg_i
);

  localparam int REG_COUNT = ewsf_pkg::REG_COUNT;

  logic [ewsf_pkg::WEIGHT_W-1:0] weight_q [REG_COUNT];

  logic busy_q, inj_left_q, inj_right_q, pend_q;
  logic in_acc, out_load;

  logic signed [ewsf_pkg::CNT_W-1:0] left_neg;

  ewsf_pkg::hist_t hist [WINDOW_TAPS+1];
  ewsf_pkg::tok_t  tok  [WINDOW_TAPS+1];
  ewsf_pkg::res_t  res;

  logic signed [ewsf_pkg::FILT_W-1:0] left_filt_q, right_filt_q;
  logic signed [ewsf_pkg::SPD_W-1:0]  left_spd_q, right_spd_q;

  logic                               out_valid_q;
  logic signed [ewsf_pkg::FILT_W-1:0] out_lf_q, out_rf_q;
  logic signed [ewsf_pkg::SPD_W-1:0]  out_ls_q, out_rs_q;

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        weight_q[i] <= (i == int'(ewsf_pkg::REG_SPEED_SCALE)) ? ewsf_pkg::SCALE_RESET
                                                               : ewsf_pkg::TAP_RESET;
      end
    end else if (cfg_i.valid) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_i.index == ewsf_pkg::REG_IDX_W'(i)) begin
          weight_q[i] <= cfg_i.data;
        end
      end
    end
  end

  // input side
  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;
  assign left_neg   = (in_i.left_count == ewsf_pkg::CNT_MIN) ? ewsf_pkg::CNT_MAX
                                                             : -in_i.left_count;

  assign hist[0] = '{left: left_neg, right: in_i.right_count};
  // left sum enters the chain first, right in the cycle after
  assign tok[0]  = '{valid: inj_left_q || inj_right_q, is_right: inj_right_q, psum: '0};

  for (genvar g = 0; g < WINDOW_TAPS; g++) begin : g_cell
    ewsf_tap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (in_acc),
      .hist_i   (hist[g]),
      .hist_o   (hist[g+1]),
      .weight_i (weight_q[g]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  ewsf_speed_unit u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok[WINDOW_TAPS]),
    .scale_i (weight_q[ewsf_pkg::REG_SPEED_SCALE]),
    .res_o   (res)
  );

  assign out_load = pend_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      inj_left_q  <= 1'b0;
      inj_right_q <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      inj_left_q  <= in_acc;
      inj_right_q <= inj_left_q;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (res.valid && res.is_right) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      if (res.is_right) begin
        right_filt_q <= res.filt;
        right_spd_q  <= res.speed;
      end else begin
        left_filt_q <= res.filt;
        left_spd_q  <= res.speed;
      end
    end
    if (out_load) begin
      out_lf_q <= left_filt_q;
      out_rf_q <= right_filt_q;
      out_ls_q <= left_spd_q;
      out_rs_q <= right_spd_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_filtered  = out_lf_q;
  assign out_o.right_filtered = out_rf_q;
  assign out_o.left_speed     = out_ls_q;
  assign out_o.right_speed    = out_rs_q;

  // nothing travels the chain between items
  a_chain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !tok[0].valid && !tok[WINDOW_TAPS].valid)
    else $error("token in tap chain while idle");

  a_pend_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> busy_q)
    else $error("pending result without an item in flight");

  // right result always directly follows the left one
  a_side_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.is_right |-> $past(res.valid && !res.is_right))
    else $error("right result not preceded by left result");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !pend_q)
    else $error("new result while previous still pending");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ewsf_pkg::*;

  localparam int TAPS        = 4;
  localparam int LATENCY     = TAPS + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_TICKS  = 950;
  localparam int RAND_PHASES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [CNT_W-1:0] left;
    logic signed [CNT_W-1:0] right;
  } tick_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] left_filt;
    logic signed [FILT_W-1:0] right_filt;
    logic signed [SPD_W-1:0]  left_spd;
    logic signed [SPD_W-1:0]  right_spd;
  } wheel_speed_t;

  logic clk;
  logic rst_n;

  ewsf_in_if  in_if  ();
  ewsf_out_if out_if ();
  ewsf_cfg_if cfg_if ();

  encoder_weighted_speed_filter_unit #(
    .WINDOW_TAPS(TAPS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // predictor state: registers 0..3 are tap weights, 4 is the speed scale
  logic [WEIGHT_W-1:0]     coef [REG_COUNT];
  logic signed [CNT_W-1:0] wheel_hist [2][MAX_TAPS];

  tick_t        tick_q [$];
  wheel_speed_t speed_q [$];

  int  mismatches;
  int  quiet_cycles;
  int  tick_gap;
  int  ready_stall;
  bit  tick_taken;
  bit  calm;

  wire in_fire  = in_if.valid && in_if.ready;
  wire out_fire = out_if.valid && out_if.ready;
  wire cfg_fire = cfg_if.valid && cfg_if.ready;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shift both histories and work out the filtered counts and speeds of one tick
  task automatic filter_tick(input logic signed [CNT_W-1:0] lc,
                             input logic signed [CNT_W-1:0] rc);
    longint                  neg;
    longint                  acc;
    longint                  filt;
    longint                  prod;
    logic signed [CNT_W-1:0] newest [2];
    logic signed [FILT_W-1:0] filt_v [2];
    logic signed [SPD_W-1:0]  spd_v [2];
    neg = -longint'(lc);
    if (neg > longint'(CNT_MAX)) neg = longint'(CNT_MAX);
    newest[0] = neg[CNT_W-1:0];
    newest[1] = rc;
    for (int s = 0; s < 2; s++) begin
      for (int i = TAPS - 1; i > 0; i--) wheel_hist[s][i] = wheel_hist[s][i-1];
      wheel_hist[s][0] = newest[s];
      acc = 0;
      for (int i = 0; i < TAPS; i++)
        acc += longint'(wheel_hist[s][i]) * longint'({1'b0, coef[i]});
      // truncate toward zero
      filt = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
      // speed rounds toward minus infinity
      prod = filt * longint'({1'b0, coef[REG_SPEED_SCALE]});
      filt_v[s] = filt[FILT_W-1:0];
      spd_v[s]  = prod[SPD_SHIFT +: SPD_W];
    end
    speed_q.push_back('{filt_v[0], filt_v[1], spd_v[0], spd_v[1]});
  endtask

  function automatic logic signed [CNT_W-1:0] rand_count();
    logic signed [CNT_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = CNT_MIN;
      1:       v = CNT_MAX;
      2: begin
        v = CNT_W'($urandom_range(0, 64));
        v = v - 16'sd32;
      end
      default: v = CNT_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    logic [WEIGHT_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2:       v = TAP_RESET;
      default: v = WEIGHT_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    // indexes past the last register are dropped by the block
    if (idx < REG_COUNT) coef[idx] = val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || speed_q.size() != 0) @(posedge clk);
  endtask

  // stimulus and run control
  initial begin
    int per_phase;
    int run_len;
    tick_t t;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.left_count  = '0;
    in_if.right_count = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_TAP_ZERO;
    cfg_if.data    = '0;
    calm           = 1'b0;
    for (int i = 0; i < REG_COUNT - 1; i++) coef[i] = TAP_RESET;
    coef[REG_SPEED_SCALE] = SCALE_RESET;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < MAX_TAPS; i++) wheel_hist[s][i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset weights: extremes, left negation saturating on the most negative count
    tick_q.push_back('{16'sd0, 16'sd0});
    tick_q.push_back('{CNT_MIN, CNT_MIN});
    tick_q.push_back('{CNT_MIN, CNT_MAX});
    tick_q.push_back('{CNT_MAX, CNT_MIN});
    tick_q.push_back('{CNT_MAX, CNT_MAX});
    tick_q.push_back(tick_t'({-16'sd1, 16'sd1}));
    tick_q.push_back(tick_t'({16'sd1, -16'sd1}));
    tick_q.push_back(tick_t'({16'sd3, -16'sd3}));
    wait_drained();

    // full-scale weights and scale: largest sums and speeds of both signs
    write_reg(REG_TAP_ZERO, '1);
    write_reg(REG_TAP_ONE, '1);
    write_reg(REG_TAP_TWO, '1);
    write_reg(REG_TAP_THREE, '1);
    write_reg(REG_SPEED_SCALE, '1);
    end_writes();
    repeat (4) tick_q.push_back('{CNT_MIN, CNT_MIN});
    repeat (4) tick_q.push_back('{CNT_MAX, CNT_MAX});
    tick_q.push_back(tick_t'({-16'sd1, -16'sd1}));
    wait_drained();

    // zero weights and scale, then writes to unused indexes
    write_reg(REG_TAP_ZERO, '0);
    write_reg(REG_TAP_ONE, '0);
    write_reg(REG_TAP_TWO, '0);
    write_reg(REG_TAP_THREE, '0);
    write_reg(REG_SPEED_SCALE, '0);
    for (int k = REG_COUNT; k < (1 << REG_IDX_W); k++) write_reg(REG_IDX_W'(k), '1);
    end_writes();
    tick_q.push_back('{CNT_MAX, CNT_MIN});
    tick_q.push_back(tick_t'({16'sd77, -16'sd77}));
    wait_drained();

    // a single tap weight (tap two), the other taps zero
    write_reg(REG_TAP_TWO, 16'd40000);
    write_reg(REG_SPEED_SCALE, SCALE_RESET);
    end_writes();
    tick_q.push_back(tick_t'({-16'sd5, 16'sd9}));
    tick_q.push_back(tick_t'({16'sd123, -16'sd321}));
    tick_q.push_back('{CNT_MIN, CNT_MAX});
    tick_q.push_back(tick_t'({16'sd0, 16'sd0}));
    wait_drained();

    per_phase = RAND_TICKS / RAND_PHASES;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int r = 0; r < REG_COUNT; r++) write_reg(REG_IDX_W'(r), rand_weight());
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_IDX_W'($urandom_range(REG_COUNT, (1 << REG_IDX_W) - 1)),
                  WEIGHT_W'($urandom));
      end_writes();
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      run_len = 0;
      while (run_len < per_phase) begin
        t.left  = rand_count();
        t.right = rand_count();
        // steady speed now and then, so the history settles on one value
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(4, 6)) begin
            tick_q.push_back(t);
            run_len++;
          end
        end else begin
          tick_q.push_back(t);
          run_len++;
        end
      end
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && speed_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // input side: take the beat and predict its result
  always @(posedge clk) begin
    if (rst_n && in_fire) begin
      filter_tick(in_if.left_count, in_if.right_count);
      void'(tick_q.pop_front());
      tick_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !tick_taken) begin
      // beat still waiting for ready
    end else if (tick_gap > 0) begin
      tick_gap--;
      in_if.valid <= 1'b0;
    end else if (tick_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      tick_gap = $urandom_range(0, 11);
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid       <= 1'b1;
      in_if.left_count  <= tick_q[0].left;
      in_if.right_count <= tick_q[0].right;
    end
    tick_taken = 1'b0;
  end

  // output side: stall bursts on ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_stall = $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    wheel_speed_t exp_v;
    if (rst_n && out_fire) begin
      if (speed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: result beat with nothing expected lf=%0d rf=%0d ls=%0d rs=%0d",
                   out_if.left_filtered, out_if.right_filtered,
                   out_if.left_speed, out_if.right_speed);
      end else begin
        exp_v = speed_q.pop_front();
        if (out_if.left_filtered !== exp_v.left_filt ||
            out_if.right_filtered !== exp_v.right_filt ||
            out_if.left_speed !== exp_v.left_spd ||
            out_if.right_speed !== exp_v.right_spd) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb_top: mismatch exp lf=%0d rf=%0d ls=%0d rs=%0d got lf=%0d rf=%0d ls=%0d rs=%0d",
                     exp_v.left_filt, exp_v.right_filt, exp_v.left_spd, exp_v.right_spd,
                     out_if.left_filtered, out_if.right_filtered,
                     out_if.left_speed, out_if.right_speed);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

endmodule
